### rtl/urss_pkg.sv
// Package for the ultrasonic range and servo sequencer.
// Holds the shared widths, register indexes and the configuration and result structs.
// No dependencies; every other RTL file refers to it by scoped names.
`default_nettype none

package urss_pkg;

    // Width of the saturating echo counter.
    localparam int COUNT_BITS = 16;

    // Widths fixed by the register map and result fields.
    localparam int TRIG_W   = 16;
    localparam int WIN_W    = 16;
    localparam int TIMER_W  = 20;
    localparam int REPS_W   = 8;
    localparam int TICKS_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Compare width for the echo count against the window limits.
    localparam int CMP_W = (COUNT_BITS > WIN_W) ? COUNT_BITS : WIN_W;

    // Stream data widths, padded to whole bytes.
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_PERIOD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_HIGH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_HIGH       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_REPEATS  = 3'd6;

    // Register reset values.
    localparam logic [TRIG_W-1:0]  RST_TRIGGER_TICKS = 16'd50;
    localparam logic [WIN_W-1:0]   RST_WINDOW_MIN    = 16'd295;
    localparam logic [WIN_W-1:0]   RST_WINDOW_MAX    = 16'd14704;
    localparam logic [TIMER_W-1:0] RST_SERVO_PERIOD  = 20'd100000;
    localparam logic [TIMER_W-1:0] RST_NEAR_HIGH     = 20'd11000;
    localparam logic [TIMER_W-1:0] RST_FAR_HIGH      = 20'd4000;
    localparam logic [REPS_W-1:0]  RST_SERVO_REPEATS = 8'd50;

    // Configuration as seen by the sequencer core.
    typedef struct packed {
        logic [TRIG_W-1:0]  trigger_ticks;
        logic [WIN_W-1:0]   window_min_count;
        logic [WIN_W-1:0]   window_max_count;
        logic [TIMER_W-1:0] servo_period_ticks;
        logic [TIMER_W-1:0] near_high_ticks;
        logic [TIMER_W-1:0] far_high_ticks;
        logic [REPS_W-1:0]  servo_repeats;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic [TICKS_W-1:0] echo_ticks;
        logic               measure_done;
        logic               led_out;
        logic               servo_out;
        logic               trigger_out;
    } res_t;

endpackage

`default_nettype wire

### rtl/ultrasonic_range_servo_sequencer.sv
// Top level of the ultrasonic range and servo sequencer.
// Holds the configuration registers, the sample register and the output handshake.
// Depends on urss_pkg and urss_core.
//
// The block takes one echo sample per transfer, one transfer per clock unless
// backpressure stalls it, and returns exactly one result for each sample. A
// sample passes through the sample register and then the sequencer step into
// the result register; the step waits while the result register is full and
// not being taken. The sustained rate is one sample per cycle while results
// are taken. Backpressure on the result side stalls the input side only when
// both the result register and the sample register are full. Configuration
// writes are always accepted and should only be made while no sample is in
// flight. No clearing pass follows reset.
`default_nettype none

module ultrasonic_range_servo_sequencer (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Input stream.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [urss_pkg::S_DATA_W-1:0]      s_tdata,   // [0] echo_level, rest zero
    // Result stream.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [urss_pkg::M_DATA_W-1:0]           m_tdata,   // [0] trigger_out,
                                                               // [1] servo_out, [2] led_out,
                                                               // [3] measure_done,
                                                               // [19:4] echo_ticks, rest zero
    // Configuration write channel.
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [urss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [urss_pkg::CFG_DATA_W-1:0]    cfg_data
);

    urss_pkg::cfg_t cfg_reg;
    logic           in_valid_reg;
    logic           in_echo_reg;
    logic           out_valid_reg;
    logic           out_free;
    logic           step;
    urss_pkg::res_t res;

    // Handshake: the result register frees when empty or being taken.
    assign out_free  = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_ticks      <= urss_pkg::RST_TRIGGER_TICKS;
            cfg_reg.window_min_count   <= urss_pkg::RST_WINDOW_MIN;
            cfg_reg.window_max_count   <= urss_pkg::RST_WINDOW_MAX;
            cfg_reg.servo_period_ticks <= urss_pkg::RST_SERVO_PERIOD;
            cfg_reg.near_high_ticks    <= urss_pkg::RST_NEAR_HIGH;
            cfg_reg.far_high_ticks     <= urss_pkg::RST_FAR_HIGH;
            cfg_reg.servo_repeats      <= urss_pkg::RST_SERVO_REPEATS;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                urss_pkg::REG_TRIGGER_TICKS:
                    cfg_reg.trigger_ticks <= cfg_data[urss_pkg::TRIG_W-1:0];
                urss_pkg::REG_WINDOW_MIN:
                    cfg_reg.window_min_count <= cfg_data[urss_pkg::WIN_W-1:0];
                urss_pkg::REG_WINDOW_MAX:
                    cfg_reg.window_max_count <= cfg_data[urss_pkg::WIN_W-1:0];
                urss_pkg::REG_SERVO_PERIOD:
                    cfg_reg.servo_period_ticks <= cfg_data[urss_pkg::TIMER_W-1:0];
                urss_pkg::REG_NEAR_HIGH:
                    cfg_reg.near_high_ticks <= cfg_data[urss_pkg::TIMER_W-1:0];
                urss_pkg::REG_FAR_HIGH:
                    cfg_reg.far_high_ticks <= cfg_data[urss_pkg::TIMER_W-1:0];
                urss_pkg::REG_SERVO_REPEATS:
                    cfg_reg.servo_repeats <= cfg_data[urss_pkg::REPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sample register: filled on an input transfer, drained by a step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_echo_reg <= s_tdata[0];
        end
    end

    // Result valid flag; the payload sits in the core's result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    urss_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .echo    (in_echo_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = urss_pkg::M_DATA_W'({res.echo_ticks, res.measure_done,
                                           res.led_out, res.servo_out, res.trigger_out});

endmodule

`default_nettype wire

### rtl/urss_core.sv
// Sequencer core: trigger, echo wait, echo count and servo phases.
// Holds the phase state and the result register; advances once per step.
// Depends on urss_pkg.
`default_nettype none

module urss_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           step,
    input  wire logic           echo,
    input  wire urss_pkg::cfg_t cfg,
    output urss_pkg::res_t      res
);

    typedef enum logic [1:0] {
        PH_TRIG  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_COUNT = 2'd2,
        PH_SERVO = 2'd3
    } phase_t;

    localparam logic [urss_pkg::COUNT_BITS-1:0] COUNT_LIMIT = '1;

    phase_t                            phase_reg, phase_next;
    logic [urss_pkg::TIMER_W-1:0]      timer_reg, timer_next;
    logic [urss_pkg::COUNT_BITS-1:0]   count_reg, count_next;
    logic [urss_pkg::REPS_W-1:0]       periods_reg, periods_next;
    logic                              in_window_reg, in_window_next;
    urss_pkg::res_t                    res_reg, res_next;

    logic [urss_pkg::TIMER_W:0]        timer_inc;
    logic [urss_pkg::TRIG_W-1:0]       trig_len;
    logic [urss_pkg::TIMER_W-1:0]      period_len;
    logic [urss_pkg::REPS_W-1:0]       reps;
    logic [urss_pkg::TIMER_W-1:0]      high_len;
    logic [urss_pkg::REPS_W:0]         periods_inc;
    logic [urss_pkg::CMP_W-1:0]        count_cmp;
    logic                              trig_bit;
    logic                              servo_bit;
    logic                              done_bit;

    // Zero lengths and counts are treated as one.
    assign trig_len   = (cfg.trigger_ticks == '0) ? urss_pkg::TRIG_W'(1) : cfg.trigger_ticks;
    assign period_len = (cfg.servo_period_ticks == '0) ?
                        urss_pkg::TIMER_W'(1) : cfg.servo_period_ticks;
    assign reps       = (cfg.servo_repeats == '0) ? urss_pkg::REPS_W'(1) : cfg.servo_repeats;
    assign high_len   = in_window_reg ? cfg.near_high_ticks : cfg.far_high_ticks;

    assign timer_inc   = {1'b0, timer_reg} + (urss_pkg::TIMER_W+1)'(1);
    assign periods_inc = {1'b0, periods_reg} + (urss_pkg::REPS_W+1)'(1);
    assign count_cmp   = urss_pkg::CMP_W'(count_reg);

    // Next state and result for one sample.
    always_comb begin
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        count_next     = count_reg;
        periods_next   = periods_reg;
        in_window_next = in_window_reg;
        trig_bit       = 1'b0;
        servo_bit      = 1'b0;
        done_bit       = 1'b0;
        unique case (phase_reg)
            PH_WAIT: begin
                if (echo) begin
                    count_next = urss_pkg::COUNT_BITS'(1);
                    phase_next = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (echo) begin
                    // Saturate rather than wrap.
                    if (count_reg != COUNT_LIMIT) begin
                        count_next = count_reg + urss_pkg::COUNT_BITS'(1);
                    end
                end else begin
                    in_window_next =
                        (count_cmp >= urss_pkg::CMP_W'(cfg.window_min_count)) &&
                        (count_cmp <= urss_pkg::CMP_W'(cfg.window_max_count));
                    done_bit     = 1'b1;
                    phase_next   = PH_SERVO;
                    timer_next   = '0;
                    periods_next = '0;
                end
            end
            PH_SERVO: begin
                servo_bit = (timer_reg < high_len);
                if (timer_inc >= (urss_pkg::TIMER_W+1)'(period_len)) begin
                    timer_next = '0;
                    if (periods_inc >= (urss_pkg::REPS_W+1)'(reps)) begin
                        periods_next = '0;
                        phase_next   = PH_TRIG;
                    end else begin
                        periods_next = periods_inc[urss_pkg::REPS_W-1:0];
                    end
                end else begin
                    timer_next = timer_inc[urss_pkg::TIMER_W-1:0];
                end
            end
            default: begin
                // Trigger phase.
                trig_bit = 1'b1;
                if (timer_inc >= (urss_pkg::TIMER_W+1)'(trig_len)) begin
                    timer_next = '0;
                    phase_next = PH_WAIT;
                end else begin
                    timer_next = timer_inc[urss_pkg::TIMER_W-1:0];
                end
            end
        endcase

        res_next.trigger_out  = trig_bit;
        res_next.servo_out    = servo_bit;
        res_next.led_out      = in_window_next;
        res_next.measure_done = done_bit;
        res_next.echo_ticks   = urss_pkg::TICKS_W'(count_next);
    end

    // State and result register, advanced on each sample step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TRIG;
            timer_reg     <= '0;
            count_reg     <= '0;
            periods_reg   <= '0;
            in_window_reg <= 1'b0;
        end else if (step) begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            count_reg     <= count_next;
            periods_reg   <= periods_next;
            in_window_reg <= in_window_next;
        end
        if (step) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

### rtl/urss_checker.sv
// Port-level checker for the ultrasonic range and servo sequencer.
// Watches the top level's ports only and is attached by the bind below.
// Depends on urss_pkg.
`default_nettype none

module urss_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [urss_pkg::M_DATA_W-1:0]  m_tdata
);

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Trigger and servo pins are never driven together.
    a_pins_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("trigger and servo high together");

    // A completed measurement happens outside the trigger and servo phases.
    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[0] && !m_tdata[1])
        else $error("measurement completed during trigger or servo");

    // With the result side empty, the input side never stalls.
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result side empty");

endmodule

bind ultrasonic_range_servo_sequencer urss_checker u_urss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### test/urss_tick_checker.sv
// Scoreboard for the ultrasonic range and servo sequencer.
// Watches the sample, result and register channels, predicts each result and compares them.
// Depends on urss_pkg for the widths, the register indexes and the result layout.

module urss_tick_checker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic [urss_pkg::S_DATA_W-1:0]      s_tdata,   // [0] echo_level, rest zero
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [urss_pkg::M_DATA_W-1:0]      m_tdata,   // [0] trigger_out,
                                                               // [1] servo_out, [2] led_out,
                                                               // [3] measure_done,
                                                               // [19:4] echo_ticks, rest zero
    input  wire logic                               cfg_valid,
    input  wire logic                               cfg_ready,
    input  wire logic [urss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [urss_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int unsigned                             failures,
    output int unsigned                             awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        SEQ_TRIGGER = 2'd0,
        SEQ_WAIT    = 2'd1,
        SEQ_COUNT   = 2'd2,
        SEQ_SERVO   = 2'd3
    } seq_phase_t;

    // Own copy of the register file and the sequencer state.
    urss_pkg::cfg_t                  regs;
    seq_phase_t                      phase;
    logic [urss_pkg::TIMER_W-1:0]    phase_timer;
    logic [urss_pkg::COUNT_BITS-1:0] echo_count;
    logic [urss_pkg::REPS_W-1:0]     periods_done;
    logic                            in_window;

    urss_pkg::res_t ticks_due[$];
    int unsigned    bad_count = 0;

    // Advances the sequencer by one tick and returns the result that tick produces.
    function automatic urss_pkg::res_t sequencer_tick(logic echo);
        logic [urss_pkg::TIMER_W:0]   timer_next;
        logic [urss_pkg::TIMER_W-1:0] period;
        logic [urss_pkg::TIMER_W-1:0] high_time;
        logic [urss_pkg::TRIG_W-1:0]  trig_len;
        logic [urss_pkg::REPS_W-1:0]  reps;
        urss_pkg::res_t               r;
        r = '0;
        timer_next = {1'b0, phase_timer} + 1'b1;
        case (phase)
            SEQ_WAIT: begin
                // No timeout: the first high sample starts the count.
                if (echo) begin
                    echo_count = 1;
                    phase = SEQ_COUNT;
                end
            end
            SEQ_COUNT: begin
                if (echo) begin
                    if (echo_count != '1)
                        echo_count = echo_count + 1'b1;
                end else begin
                    in_window = (echo_count >= regs.window_min_count) &&
                                (echo_count <= regs.window_max_count);
                    r.measure_done = 1'b1;
                    phase = SEQ_SERVO;
                    phase_timer = '0;
                    periods_done = '0;
                end
            end
            SEQ_SERVO: begin
                // Zero period and zero repeat count both behave as one.
                period = regs.servo_period_ticks;
                if (period == '0)
                    period = 1;
                reps = regs.servo_repeats;
                if (reps == '0)
                    reps = 1;
                high_time = in_window ? regs.near_high_ticks : regs.far_high_ticks;
                r.servo_out = (phase_timer < high_time);
                if (timer_next >= {1'b0, period}) begin
                    phase_timer = '0;
                    periods_done = periods_done + 1'b1;
                    if (periods_done >= reps) begin
                        periods_done = '0;
                        phase = SEQ_TRIGGER;
                    end
                end else begin
                    phase_timer = timer_next[urss_pkg::TIMER_W-1:0];
                end
            end
            default: begin
                // Trigger pulse; the echo is ignored here.
                trig_len = regs.trigger_ticks;
                if (trig_len == '0)
                    trig_len = 1;
                r.trigger_out = 1'b1;
                if (timer_next >= trig_len) begin
                    phase_timer = '0;
                    phase = SEQ_WAIT;
                end else begin
                    phase_timer = timer_next[urss_pkg::TIMER_W-1:0];
                end
            end
        endcase
        r.led_out = in_window;
        r.echo_ticks = echo_count[urss_pkg::TICKS_W-1:0];
        return r;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            bad_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    // Register writes, sample transfers and result transfers, all seen at the clock edge.
    always @(posedge aclk) begin : watch
        urss_pkg::res_t due;
        urss_pkg::res_t seen;
        if (!aresetn) begin
            regs.trigger_ticks      = urss_pkg::RST_TRIGGER_TICKS;
            regs.window_min_count   = urss_pkg::RST_WINDOW_MIN;
            regs.window_max_count   = urss_pkg::RST_WINDOW_MAX;
            regs.servo_period_ticks = urss_pkg::RST_SERVO_PERIOD;
            regs.near_high_ticks    = urss_pkg::RST_NEAR_HIGH;
            regs.far_high_ticks     = urss_pkg::RST_FAR_HIGH;
            regs.servo_repeats      = urss_pkg::RST_SERVO_REPEATS;
            phase        = SEQ_TRIGGER;
            phase_timer  = '0;
            echo_count   = '0;
            periods_done = '0;
            in_window    = 1'b0;
            ticks_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    urss_pkg::REG_TRIGGER_TICKS:
                        regs.trigger_ticks = cfg_data[urss_pkg::TRIG_W-1:0];
                    urss_pkg::REG_WINDOW_MIN:
                        regs.window_min_count = cfg_data[urss_pkg::WIN_W-1:0];
                    urss_pkg::REG_WINDOW_MAX:
                        regs.window_max_count = cfg_data[urss_pkg::WIN_W-1:0];
                    urss_pkg::REG_SERVO_PERIOD:
                        regs.servo_period_ticks = cfg_data[urss_pkg::TIMER_W-1:0];
                    urss_pkg::REG_NEAR_HIGH:
                        regs.near_high_ticks = cfg_data[urss_pkg::TIMER_W-1:0];
                    urss_pkg::REG_FAR_HIGH:
                        regs.far_high_ticks = cfg_data[urss_pkg::TIMER_W-1:0];
                    urss_pkg::REG_SERVO_REPEATS:
                        regs.servo_repeats = cfg_data[urss_pkg::REPS_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                ticks_due.push_back(sequencer_tick(s_tdata[0]));
            if (m_tvalid && m_tready) begin
                seen = m_tdata[$bits(urss_pkg::res_t)-1:0];
                if (ticks_due.size() == 0) begin
                    bad_count++;
                    $display("%0t: result transfer with nothing expected, %s %0h",
                             $time, "expected none, actual", m_tdata);
                end else begin
                    due = ticks_due.pop_front();
                    check_field("trigger_out", due.trigger_out, seen.trigger_out);
                    check_field("servo_out", due.servo_out, seen.servo_out);
                    check_field("led_out", due.led_out, seen.led_out);
                    check_field("measure_done", due.measure_done, seen.measure_done);
                    check_field("echo_ticks", due.echo_ticks, seen.echo_ticks);
                    check_field("tdata padding", 0,
                                m_tdata[urss_pkg::M_DATA_W-1:$bits(urss_pkg::res_t)]);
                end
            end
        end
        awaiting <= ticks_due.size();
        failures <= bad_count;
    end

endmodule

### test/tb_top.sv
// Top of the sequencer testbench: clock, reset, stimulus, register programming and verdict.
// Depends on urss_pkg, the ultrasonic_range_servo_sequencer RTL and urss_tick_checker.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        IDLE_NONE,
        IDLE_LIGHT,
        IDLE_HEAVY
    } idle_style_t;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned RANDOM_PHASES  = 10;
    localparam int unsigned PHASE_ITEMS    = 135;
    localparam int unsigned LONG_HIGH      = 48;
    localparam int unsigned PULSE_CEILING  = 40;
    localparam logic [urss_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [urss_pkg::S_DATA_W-1:0]   s_tdata   = '0;   // [0] echo_level, rest zero
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [urss_pkg::M_DATA_W-1:0]   m_tdata;          // [0] trigger_out, [1] servo_out,
                                                       // [2] led_out, [3] measure_done,
                                                       // [19:4] echo_ticks
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [urss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [urss_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int unsigned failures;
    int unsigned awaiting;
    int unsigned quiet_cycles = 0;
    idle_style_t idle_style   = IDLE_HEAVY;

    always #5 aclk = ~aclk;

    ultrasonic_range_servo_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    urss_tick_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .awaiting  (awaiting)
    );

    // Abort when no transfer of any kind has happened for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ultrasonic_range_servo_sequencer regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Number of cycles a side holds off before its next transfer.
    function automatic int unsigned draw_wait();
        case (idle_style)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
            default:    return $urandom_range(0, 12);
        endcase
    endfunction

    // Result side: random stalls between transfers.
    initial begin : result_sink
        int unsigned gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = draw_wait();
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_echo(logic level);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(urss_pkg::S_DATA_W-1){1'b0}}, level};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    task automatic send_run(logic level, int unsigned count);
        repeat (count) send_echo(level);
    endtask

    // Echo low for a while, then high for the given number of ticks.
    task automatic send_pulse(int unsigned low, int unsigned high);
        send_run(1'b0, low);
        send_run(1'b1, high);
    endtask

    // Sends the lowest count bits of the pattern, most significant first.
    task automatic send_pattern(logic [31:0] bits, int count);
        for (int i = count - 1; i >= 0; i--)
            send_echo(bits[i]);
    endtask

    // Stops sending and waits until every expected result has been seen.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaiting != 0) @(posedge aclk);
    endtask

    // One register write; bits above the register's width carry random junk.
    task automatic write_reg(logic [urss_pkg::CFG_IDX_W-1:0] idx,
                             logic [urss_pkg::CFG_DATA_W-1:0] value);
        logic [urss_pkg::CFG_DATA_W-1:0] keep;
        logic [urss_pkg::CFG_DATA_W-1:0] junk;
        junk = urss_pkg::CFG_DATA_W'($urandom);
        case (idx)
            urss_pkg::REG_TRIGGER_TICKS, urss_pkg::REG_WINDOW_MIN, urss_pkg::REG_WINDOW_MAX:
                keep = (20'd1 << urss_pkg::WIN_W) - 20'd1;
            urss_pkg::REG_SERVO_REPEATS:
                keep = (20'd1 << urss_pkg::REPS_W) - 20'd1;
            default:
                keep = '1;
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (value & keep) | (junk & ~keep);
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
    endtask

    task automatic program_regs(urss_pkg::cfg_t c);
        write_reg(urss_pkg::REG_TRIGGER_TICKS, urss_pkg::CFG_DATA_W'(c.trigger_ticks));
        write_reg(urss_pkg::REG_WINDOW_MIN, urss_pkg::CFG_DATA_W'(c.window_min_count));
        write_reg(urss_pkg::REG_WINDOW_MAX, urss_pkg::CFG_DATA_W'(c.window_max_count));
        write_reg(urss_pkg::REG_SERVO_PERIOD, c.servo_period_ticks);
        write_reg(urss_pkg::REG_NEAR_HIGH, c.near_high_ticks);
        write_reg(urss_pkg::REG_FAR_HIGH, c.far_high_ticks);
        write_reg(urss_pkg::REG_SERVO_REPEATS, urss_pkg::CFG_DATA_W'(c.servo_repeats));
        cfg_valid <= 1'b0;
    endtask

    // Echo pulses spaced so that most land in the wait phase, with lengths
    // around the window edges; one pulse in eight is short noise instead.
    task automatic run_measurements(urss_pkg::cfg_t c, int unsigned budget);
        int unsigned trig_len;
        int unsigned period;
        int unsigned reps;
        int unsigned recover;
        int unsigned low;
        int unsigned sent;
        int          high;
        int          lo_edge;
        int          hi_edge;
        trig_len = (c.trigger_ticks == 0) ? 1 : int'(c.trigger_ticks);
        period   = (c.servo_period_ticks == 0) ? 1 : int'(c.servo_period_ticks);
        reps     = (c.servo_repeats == 0) ? 1 : int'(c.servo_repeats);
        recover  = trig_len + period * reps;
        lo_edge  = int'(c.window_min_count);
        hi_edge  = int'(c.window_max_count);
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 7) == 0) begin
                low  = $urandom_range(0, 6);
                high = $urandom_range(1, 4);
            end else begin
                low = recover + $urandom_range(1, 4);
                case ($urandom_range(0, 6))
                    0: high = lo_edge - 1;
                    1: high = lo_edge;
                    2: high = lo_edge + 1;
                    3: high = hi_edge - 1;
                    4: high = hi_edge;
                    5: high = hi_edge + 1;
                    default: high = $urandom_range(1, PULSE_CEILING);
                endcase
                if (high < 1)
                    high = 1;
                if (high > PULSE_CEILING)
                    high = $urandom_range(1, PULSE_CEILING);
            end
            send_pulse(low, high);
            sent += low + high;
        end
    endtask

    initial begin : stimulus
        urss_pkg::cfg_t setting;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: echo during the trigger pulse is ignored.
        idle_style = IDLE_LIGHT;
        send_pattern(32'b1101, 4);
        settle();

        // Zero trigger length, period and repeat count, a high time that covers
        // the whole period, and a write to an unmapped index.
        setting.trigger_ticks      = 0;
        setting.window_min_count   = 2;
        setting.window_max_count   = 3;
        setting.servo_period_ticks = 0;
        setting.near_high_ticks    = 5;
        setting.far_high_ticks     = 0;
        setting.servo_repeats      = 0;
        write_reg(REG_UNMAPPED, urss_pkg::CFG_DATA_W'($urandom));
        program_regs(setting);
        // Counts of 2 (window floor), 4 (above), 1 (below) and 3 (window ceiling).
        send_pattern(32'b011000111100010001110, 21);
        settle();

        // Every register at its largest value; the servo period runs long.
        setting.trigger_ticks      = '1;
        setting.window_min_count   = '1;
        setting.window_max_count   = '1;
        setting.servo_period_ticks = '1;
        setting.near_high_ticks    = '1;
        setting.far_high_ticks     = '1;
        setting.servo_repeats      = '1;
        program_regs(setting);
        idle_style = IDLE_HEAVY;
        repeat (40) send_echo(1'($urandom_range(0, 1)));
        settle();

        // Random small settings, including a window that takes everything
        // and one that takes nothing.
        for (int unsigned k = 0; k < RANDOM_PHASES; k++) begin
            setting.trigger_ticks      = urss_pkg::TRIG_W'($urandom_range(0, 6));
            setting.window_min_count   = urss_pkg::WIN_W'($urandom_range(0, 20));
            setting.window_max_count   = urss_pkg::WIN_W'($urandom_range(0, 30));
            setting.servo_period_ticks = urss_pkg::TIMER_W'($urandom_range(0, 8));
            setting.near_high_ticks    = urss_pkg::TIMER_W'($urandom_range(0, 10));
            setting.far_high_ticks     = urss_pkg::TIMER_W'($urandom_range(0, 10));
            setting.servo_repeats      = urss_pkg::REPS_W'($urandom_range(0, 3));
            if (k == 0) begin
                setting.window_min_count = '0;
                setting.window_max_count = '1;
            end else if (k == 1) begin
                setting.window_min_count = 18;
                setting.window_max_count = 6;
            end
            program_regs(setting);
            idle_style = idle_style_t'(k % 3);
            run_measurements(setting, PHASE_ITEMS);
            settle();
        end

        // One longer echo measured against a window with an open top.
        setting.trigger_ticks      = 1;
        setting.window_min_count   = 40;
        setting.window_max_count   = '1;
        setting.servo_period_ticks = 1;
        setting.near_high_ticks    = 1;
        setting.far_high_ticks     = 0;
        setting.servo_repeats      = 1;
        program_regs(setting);
        idle_style = IDLE_NONE;
        send_pulse(12, LONG_HIGH);
        send_run(1'b0, 6);
        settle();

        repeat (8) @(posedge aclk);
        if (failures == 0 && awaiting == 0) begin
            $display("ultrasonic_range_servo_sequencer regression: pass");
        end else begin
            $display("ultrasonic_range_servo_sequencer regression: fail");
        end
        $finish;
    end

endmodule

### files.f
rtl/urss_pkg.sv
rtl/urss_core.sv
rtl/ultrasonic_range_servo_sequencer.sv
rtl/urss_checker.sv
test/urss_tick_checker.sv
test/tb_top.sv
